// ===== design/scc_pkg.sv =====
package scc_pkg;

  localparam int unsigned IterationsDefault = 16;
  localparam int unsigned DataWidthDefault  = 16;
  localparam int unsigned TabLen            = 24;
  localparam int unsigned QueueDepth        = 2;

  // Angles: pi = 2^31, carried in 34 bits so sums past +-pi never wrap.
  localparam int unsigned AngW = 34;
  localparam logic signed [AngW-1:0] AngHalfPi = 34'sd1073741824;

  typedef enum logic [0:0] {
    FuncToSpherical = 1'b0,
    FuncToCartesian = 1'b1
  } func_e;

  // One request as the front end hands it to the back end.
  typedef struct packed {
    logic              func;
    logic              xy_zero;
    logic              all_zero;
    logic signed [16:0] a;   // x, or radius
    logic signed [16:0] b;   // y, or polar (signed, folded to +-pi)
    logic signed [16:0] c;   // z, or azimuth
  } req_t;

  function automatic logic signed [AngW-1:0] atan_lut(input int unsigned i);
    logic signed [AngW-1:0] t;
    t = '0;
    unique case (i)
      0: t = 34'sd536870912;   1: t = 34'sd316933406;
      2: t = 34'sd167458907;   3: t = 34'sd85004756;
      4: t = 34'sd42667331;    5: t = 34'sd21354465;
      6: t = 34'sd10679838;    7: t = 34'sd5340245;
      8: t = 34'sd2670163;     9: t = 34'sd1335087;
      10: t = 34'sd667544;     11: t = 34'sd333772;
      12: t = 34'sd166886;     13: t = 34'sd83443;
      14: t = 34'sd41722;      15: t = 34'sd20861;
      16: t = 34'sd10430;      17: t = 34'sd5215;
      18: t = 34'sd2608;       19: t = 34'sd1304;
      20: t = 34'sd652;        21: t = 34'sd326;
      22: t = 34'sd163;        23: t = 34'sd81;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Restoring long division, used only while the gain constant is elaborated.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // CORDIC gain inverse in Q30, evaluated at elaboration.
  function automatic logic [31:0] gain_q30(input int unsigned n);
    logic [63:0] k2, res, bit_v;
    int unsigned m;
    k2 = 64'd1 << 60;
    res = '0;
    bit_v = 64'd1 << 62;
    m = (n > TabLen) ? TabLen : n;
    for (int unsigned i = 0; i < TabLen; i++) begin
      if (i < m) k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
    end
    for (int unsigned j = 0; j < 32; j++) begin
      if (bit_v > k2) bit_v = bit_v >> 2;
    end
    for (int unsigned j = 0; j < 32; j++) begin
      if (bit_v != 0) begin
        if (k2 >= res + bit_v) begin
          k2 = k2 - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res[31:0];
  endfunction

endpackage

// ===== design/scc_cordic.sv =====
// Unrolled CORDIC, one micro-rotation per register stage, plus a
// two-stage gain removal. Vectoring mode drives y to zero and collects
// the angle; rotation mode drives the angle to zero. Side data rides along.
module scc_cordic #(
  parameter int unsigned Iterations = scc_pkg::IterationsDefault,
  parameter int unsigned Dw         = 34,
  parameter int unsigned SideW      = 8,
  parameter bit          Vectoring  = 1'b1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [Dw-1:0]         x_i,
  input  logic signed [Dw-1:0]         y_i,
  input  logic signed [scc_pkg::AngW-1:0] a_i,
  input  logic [SideW-1:0]             side_i,
  output logic                         valid_o,
  output logic signed [Dw-1:0]         x_o,
  output logic signed [Dw-1:0]         y_o,
  output logic signed [scc_pkg::AngW-1:0] a_o,
  output logic [SideW-1:0]             side_o
);

  localparam int unsigned N = (Iterations > scc_pkg::TabLen) ? scc_pkg::TabLen : Iterations;
  localparam int unsigned S = N + 1;
  localparam int unsigned AW = scc_pkg::AngW;
  localparam logic [31:0] K = scc_pkg::gain_q30(Iterations);
  localparam int unsigned MW = (Dw > 30) ? Dw : 31;
  localparam int unsigned HW = MW - 30;

  logic               vld_q [S+2];
  logic signed [Dw-1:0] x_q [S+1];
  logic signed [Dw-1:0] y_q [S+1];
  logic signed [AW-1:0] a_q [S+2];
  logic [SideW-1:0]   sd_q [S+2];

  // Gain removal: |v|*K/2^30 split into high and low partial products.
  logic [MW-1:0] mx, my;
  logic sx_q, sy_q;
  logic [Dw+1:0] hx_q, lx_q, hy_q, ly_q;

  // Quadrant pre-rotation.
  logic signed [Dw-1:0] px, py;
  logic signed [AW-1:0] pa;
  always_comb begin
    px = x_i;
    py = y_i;
    pa = a_i;
    if (Vectoring) begin
      pa = '0;
      if (x_i < 0) begin
        if (y_i >= 0) begin
          px = y_i; py = -x_i; pa = scc_pkg::AngHalfPi;
        end else begin
          px = -y_i; py = x_i; pa = -scc_pkg::AngHalfPi;
        end
      end
    end else begin
      py = '0;
      if (a_i > scc_pkg::AngHalfPi) begin
        px = '0; py = x_i; pa = a_i - scc_pkg::AngHalfPi;
      end else if (a_i < -scc_pkg::AngHalfPi) begin
        px = '0; py = -x_i; pa = a_i + scc_pkg::AngHalfPi;
      end
    end
  end

  assign mx = MW'($unsigned(x_q[N][Dw-1] ? Dw'(-x_q[N]) : x_q[N]));
  assign my = MW'($unsigned(y_q[N][Dw-1] ? Dw'(-y_q[N]) : y_q[N]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < S + 2; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < S + 2; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= px;
      y_q[0] <= py;
      a_q[0] <= pa;
      sd_q[0] <= side_i;
      for (int unsigned g = 0; g < N; g++) begin
        sd_q[g+1] <= sd_q[g];
        if (Vectoring ? (y_q[g] >= 0) : (a_q[g] < 0)) begin
          x_q[g+1] <= x_q[g] + (y_q[g] >>> g);
          y_q[g+1] <= y_q[g] - (x_q[g] >>> g);
        end else begin
          x_q[g+1] <= x_q[g] - (y_q[g] >>> g);
          y_q[g+1] <= y_q[g] + (x_q[g] >>> g);
        end
        if (Vectoring ? (y_q[g] >= 0) : (a_q[g] >= 0)) begin
          a_q[g+1] <= Vectoring ? a_q[g] + scc_pkg::atan_lut(g)
                                : a_q[g] - scc_pkg::atan_lut(g);
        end else begin
          a_q[g+1] <= Vectoring ? a_q[g] - scc_pkg::atan_lut(g)
                                : a_q[g] + scc_pkg::atan_lut(g);
        end
      end
      sx_q <= x_q[N][Dw-1];
      sy_q <= y_q[N][Dw-1];
      hx_q <= (Dw+2)'(HW'(mx >> 30)) * (Dw+2)'(K);
      hy_q <= (Dw+2)'(HW'(my >> 30)) * (Dw+2)'(K);
      lx_q <= (Dw+2)'((62'(mx[29:0]) * 62'(K)) >> 30);
      ly_q <= (Dw+2)'((62'(my[29:0]) * 62'(K)) >> 30);
      a_q[N+1] <= a_q[N];
      sd_q[N+1] <= sd_q[N];
      a_q[N+2] <= a_q[N+1];
      sd_q[N+2] <= sd_q[N+1];
      x_q[N+1] <= sx_q ? -Dw'(hx_q + lx_q) : Dw'(hx_q + lx_q);
      y_q[N+1] <= sy_q ? -Dw'(hy_q + ly_q) : Dw'(hy_q + ly_q);
    end
  end

  assign valid_o = vld_q[S+1];
  assign x_o     = x_q[N+1];
  assign y_o     = y_q[N+1];
  assign a_o     = a_q[N+2];
  assign side_o  = sd_q[N+2];

endmodule

// ===== design/scc_front.sv =====
// Accepts requests, classifies them and keeps a short queue for the back end.
module scc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic               func_i,
  input  logic signed [15:0] x_in_i,
  input  logic signed [15:0] y_in_i,
  input  logic signed [15:0] z_in_i,
  input  logic [15:0]        radius_in_i,
  input  logic [15:0]        polar_in_i,
  input  logic signed [15:0] azimuth_in_i,
  output logic               req_valid_o,
  input  logic               req_pop_i,
  output scc_pkg::req_t      req_o
);

  localparam int unsigned D = scc_pkg::QueueDepth;
  scc_pkg::req_t q_q [D];
  logic [$clog2(D)-1:0] wp_q, rp_q;
  logic [$clog2(D):0]   cnt_q;
  scc_pkg::req_t r;
  logic push;

  always_comb begin
    r.func = func_i;
    r.xy_zero = (x_in_i == 0) && (y_in_i == 0);
    r.all_zero = r.xy_zero && (z_in_i == 0);
    if (func_i == scc_pkg::FuncToCartesian) begin
      r.a = $signed({1'b0, radius_in_i});
      r.b = $signed({polar_in_i[15], polar_in_i});
      r.c = 17'(azimuth_in_i);
    end else begin
      r.a = 17'(x_in_i);
      r.b = 17'(y_in_i);
      r.c = 17'(z_in_i);
    end
  end

  assign ready_o = (cnt_q != D);
  assign push = valid_i && ready_o;
  assign req_valid_o = (cnt_q != 0);
  assign req_o = q_q[rp_q];

  always_ff @(posedge clk_i) if (push) q_q[wp_q] <= r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (req_pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (($clog2(D)+1)'(push)) - (($clog2(D)+1)'(req_pop_i));
    end
  end

endmodule

// ===== design/scc_back.sv =====
// Two CORDIC passes in series; mode per request decides how they are used.
module scc_back #(
  parameter int unsigned Iterations = scc_pkg::IterationsDefault,
  parameter int unsigned DataWidth  = scc_pkg::DataWidthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_pop_o,
  input  scc_pkg::req_t      req_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [16:0] x_out_o,
  output logic signed [16:0] y_out_o,
  output logic signed [16:0] z_out_o,
  output logic [15:0]        radius_out_o,
  output logic [15:0]        polar_out_o,
  output logic signed [15:0] azimuth_out_o
);

  localparam int unsigned Dw = DataWidth + 20;
  localparam int unsigned AW = scc_pkg::AngW;
  localparam int unsigned SW = 3 + 17;

  logic en, full_q, v1;
  logic signed [Dw-1:0] a_x, a_y, b_x, b_y, b_xi, b_yi;
  logic signed [AW-1:0] a_ang1, b_ang;
  logic [SW-1:0] s1;
  logic v2;

  // Pipeline advances when the output register is free or being drained.
  assign en = !full_q || ready_i;
  assign req_pop_o = req_valid_i && en;

  // One pair of chains per pass serves both directions, selected by func.
  logic signed [Dw-1:0] p1x, p1y;
  logic signed [AW-1:0] p1a;
  logic m1;
  scc_cordic #(.Iterations(Iterations), .Dw(Dw), .SideW(SW), .Vectoring(1'b1)) u_va (
    .clk_i, .rst_ni, .en_i(en), .valid_i(req_pop_o),
    .x_i(Dw'(req_i.a) <<< DataWidth), .y_i(Dw'(req_i.b) <<< DataWidth),
    .a_i('0), .side_i({req_i.func, req_i.xy_zero, req_i.all_zero, req_i.c}),
    .valid_o(v1), .x_o(a_x), .y_o(), .a_o(a_ang1), .side_o(s1)
  );
  scc_cordic #(.Iterations(Iterations), .Dw(Dw), .SideW(SW), .Vectoring(1'b0)) u_ra (
    .clk_i, .rst_ni, .en_i(en), .valid_i(req_pop_o),
    .x_i(Dw'(req_i.a) <<< DataWidth), .y_i('0),
    .a_i(AW'(req_i.b) <<< 16),
    .side_i({req_i.func, req_i.xy_zero, req_i.all_zero, req_i.c}),
    .valid_o(), .x_o(a_y), .y_o(b_x), .a_o(), .side_o()
  );

  logic f1, xyz1, az1;
  logic signed [16:0] c1;
  assign {f1, xyz1, az1, c1} = s1;
  assign m1 = f1;

  // Stage two inputs.
  always_comb begin
    if (m1 == scc_pkg::FuncToCartesian) begin
      p1x = b_x;                       // r sin(polar)
      p1y = '0;
      p1a = AW'(c1) <<< 16;            // azimuth
    end else begin
      p1x = Dw'(c1) <<< DataWidth;     // z
      p1y = xyz1 ? '0 : a_x;           // rho
      p1a = '0;
    end
  end

  logic signed [AW-1:0] az_ang;
  logic f2, all2;
  logic signed [AW-1:0] az2;
  logic signed [Dw-1:0] zc2;
  assign az_ang = xyz1 ? '0 : a_ang1;

  scc_cordic #(.Iterations(Iterations), .Dw(Dw), .SideW(AW+Dw+2), .Vectoring(1'b1)) u_vb (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .x_i(p1x), .y_i(p1y), .a_i('0),
    .side_i({f1, az1, az_ang, a_y}), .valid_o(v2), .x_o(b_xi), .y_o(), .a_o(b_ang),
    .side_o({f2, all2, az2, zc2})
  );
  scc_cordic #(.Iterations(Iterations), .Dw(Dw), .SideW(1), .Vectoring(1'b0)) u_rb (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .x_i(p1x), .y_i('0), .a_i(p1a),
    .side_i(1'b0), .valid_o(), .x_o(b_yi), .y_o(b_y), .a_o(), .side_o()
  );

  function automatic logic signed [16:0] sat17(input logic signed [Dw-1:0] v);
    logic signed [Dw-1:0] t;
    t = (v + (Dw'(1) <<< (DataWidth - 1))) >>> DataWidth;
    if (t < -65536) return -17'sd65536;
    if (t > 65535) return 17'sd65535;
    return 17'(t);
  endfunction

  logic signed [AW-1:0] pr, ar;
  logic signed [Dw-1:0] rr;
  assign rr = (b_xi + (Dw'(1) <<< (DataWidth - 1))) >>> DataWidth;
  assign pr = (b_ang + 34'sd32768) >>> 16;
  assign ar = (az2 + 34'sd32768) >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) full_q <= 1'b0;
    else if (en) full_q <= v2;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_out_o <= '0; y_out_o <= '0; z_out_o <= '0;
      radius_out_o <= '0; polar_out_o <= '0; azimuth_out_o <= '0;
      if (f2 == scc_pkg::FuncToCartesian) begin
        x_out_o <= sat17(b_yi);
        y_out_o <= sat17(b_y);
        z_out_o <= sat17(zc2);
      end else if (!all2) begin
        radius_out_o <= (rr < 0) ? 16'd0 : ((rr > 65535) ? 16'hFFFF : 16'(rr));
        polar_out_o <= (pr < 0) ? 16'd0 : ((pr > 32768) ? 16'd32768 : 16'(pr));
        azimuth_out_o <= 16'(ar);
      end
    end
  end

  assign valid_o = full_q;

endmodule

// ===== design/spherical_coordinate_convert.sv =====
// Channel  | Handshake              | Payload
// ---------+------------------------+-----------------------------------------
// request  | valid_i / ready_o      | func_i, x/y/z_in_i, radius/polar/azimuth_in_i
// result   | valid_o / ready_i      | x/y/z_out_o, radius/polar/azimuth_out_o
//
// One request per cycle is accepted while the output is taken; each result
// passes through the front queue, then two unrolled CORDIC chains in series,
// each one stage per micro-rotation plus gain stages, then the output register.
// Reset clears the queue pointers and all pipeline valid bits.
// A stalled output freezes the whole back end; the two-entry front queue
// then fills and deasserts ready_o.
module spherical_coordinate_convert #(
  parameter int unsigned ITERATIONS = scc_pkg::IterationsDefault,
  parameter int unsigned DATA_WIDTH = scc_pkg::DataWidthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic               func_i,
  input  logic signed [15:0] x_in_i,
  input  logic signed [15:0] y_in_i,
  input  logic signed [15:0] z_in_i,
  input  logic [15:0]        radius_in_i,
  input  logic [15:0]        polar_in_i,
  input  logic signed [15:0] azimuth_in_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [16:0] x_out_o,
  output logic signed [16:0] y_out_o,
  output logic signed [16:0] z_out_o,
  output logic [15:0]        radius_out_o,
  output logic [15:0]        polar_out_o,
  output logic signed [15:0] azimuth_out_o
);

  // The front end classifies each request (direction, zero vector) and queues it.
  scc_pkg::req_t req;
  logic req_valid, req_pop;

  scc_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .func_i, .x_in_i, .y_in_i, .z_in_i,
    .radius_in_i, .polar_in_i, .azimuth_in_i,
    .req_valid_o(req_valid), .req_pop_i(req_pop), .req_o(req)
  );

  // The back end runs both CORDIC passes and holds the result register.
  scc_back #(.Iterations(ITERATIONS), .DataWidth(DATA_WIDTH)) u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_pop_o(req_pop), .req_i(req),
    .valid_o, .ready_i, .x_out_o, .y_out_o, .z_out_o, .radius_out_o,
    .polar_out_o, .azimuth_out_o
  );

endmodule
